[hdl/v2xpc_pkg.sv]
// ----------------------------------------------------------------------------
// V2X plausibility check package
// Types, register codes and fixed constants shared by the plausibility check.
// ----------------------------------------------------------------------------
package v2xpc_pkg;

    localparam int ACC_W     = 112;
    localparam int MUL_W     = 34;
    localparam int ENT_W     = 97;
    localparam int BND_W     = 56;
    localparam int DIV_STEPS = 34;
    localparam int MS_PER_S  = 1000;
    localparam int MS2_PER_S = 2000;
    localparam int SCALE_ODD = 976562500;
    localparam int SCALE_SH  = 12;

    localparam logic [1:0] REG_RANGE_LIMIT = 2'd0;
    localparam logic [1:0] REG_MAX_SPEED   = 2'd1;
    localparam logic [1:0] REG_MAX_ACCEL   = 2'd2;
    localparam logic [1:0] REG_MAX_DECEL   = 2'd3;

    localparam logic [31:0] RST_RANGE_LIMIT = 32'd50000;
    localparam logic [15:0] RST_MAX_SPEED   = 16'd7000;
    localparam logic [15:0] RST_MAX_ACCEL   = 16'd500;
    localparam logic [16:0] RST_MAX_DECEL   = 17'h1FC7C;

    typedef enum logic [5:0] {
        ST_CLEAR, ST_IDLE, ST_LOAD, ST_RSQ0, ST_RSQ1, ST_RLIM, ST_DV, ST_ADT,
        ST_DDT, ST_NUM, ST_DIVSET, ST_DIV, ST_TSET, ST_P11, ST_P12, ST_P22,
        ST_XB, ST_YB, ST_UP0, ST_UP1, ST_LO0, ST_LO1, ST_DO0, ST_DO1, ST_S0,
        ST_S1, ST_S2, ST_L1, ST_L2, ST_U0, ST_U1, ST_U2, ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        SRC_ZERO, SRC_ACC, SRC_SAVE, SRC_BASE
    } t_src;

    typedef struct packed {
        logic             en;
        t_src             src;
        logic [MUL_W-1:0] op_a;
        logic [MUL_W-1:0] op_b;
        logic             neg;
        logic [5:0]       sh;
    } t_mac_ctrl;

    function automatic logic [32:0] f_absdiff(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] d;
        d = {a[31], a} - {b[31], b};
        return d[32] ? (33'd0 - d) : d;
    endfunction

endpackage

[hdl/v2x_message_plausibility_check.sv]
// ----------------------------------------------------------------------------
// V2X message plausibility check
// Per-sender message history with range, speed and kinematic consistency checks.
// ----------------------------------------------------------------------------
// Usage: a status message is one transaction on the input channel
// (i_valid/o_ready); one result transaction follows on the output channel
// (o_valid/i_ready). Registers are written on the cfg channel, which is always
// ready and must only be used while the block is idle.
// Each message runs through one shared 34x34 multiply-accumulate unit and a
// radix-2 divider under a sequencer; the 34-step division does not run for
// every message. The next message can be accepted at the earliest in the
// same cycle in which the result is presented. o_ready is high only in the
// idle state.
// The result sits in an output register; a new message is accepted while a
// result still waits, but the next result is held back until the receiver
// takes the previous one.
// After reset the history memory is swept to invalid, one entry per cycle,
// through all NUM_VEHICLES entries; no message is accepted meanwhile,
// configuration writes are. Registers return to their reset values.
// ----------------------------------------------------------------------------
module v2x_message_plausibility_check #(
    parameter int NUM_VEHICLES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_vehicle_id,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic [15:0] i_speed,
    input  logic [15:0] i_gen_time,
    input  logic signed [31:0] i_rx_pos_x,
    input  logic signed [31:0] i_rx_pos_y,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_misbehaving,
    output logic        o_had_previous,
    output logic        o_range_fail,
    output logic        o_speed_fail,
    output logic        o_speed_cons_fail,
    output logic        o_pos_cons_fail
);

    localparam int IW = (NUM_VEHICLES > 1) ? $clog2(NUM_VEHICLES) : 1;
    localparam logic [IW-1:0] CLR_LAST = IW'(NUM_VEHICLES - 1);
    localparam int AW = v2xpc_pkg::ACC_W;
    localparam int MW = v2xpc_pkg::MUL_W;
    localparam int BW = v2xpc_pkg::BND_W;

    function automatic logic [IW-1:0] f_index(input logic [7:0] vid);
        int r;
        int m;
        r = int'(vid);
        if (NUM_VEHICLES < 256) begin
            for (int j = 7; j >= 0; j--) begin
                m = NUM_VEHICLES << j;
                if (m <= 255 && r >= m) begin
                    r = r - m;
                end
            end
        end
        return IW'(r);
    endfunction

    v2xpc_pkg::t_state r_state, n_state;
    v2xpc_pkg::t_mac_ctrl mac;

    logic [31:0] r_range_limit;
    logic [15:0] r_max_speed, r_max_accel;
    logic [16:0] r_max_decel;

    logic [v2xpc_pkg::ENT_W-1:0] r_mem [NUM_VEHICLES];
    logic [v2xpc_pkg::ENT_W-1:0] r_rd;
    logic [IW-1:0] r_clr, r_idx;

    logic [31:0] r_px, r_py, r_rx, r_ry;
    logic [15:0] r_spd, r_tms, r_dt, r_v0, r_dvmag, r_t1, r_t2;
    logic [32:0] r_dxr, r_dyr, r_dxo, r_dyo;
    logic        r_dvneg, r_had, r_sf, r_rf, r_c2, r_scf, r_above;
    logic [16:0] r_apmag, r_dpmag;
    logic        r_apneg, r_dpneg;
    logic [17:0] r_kmag, r_rem;
    logic        r_kneg;
    logic [33:0] r_quo, r_p11, r_p12, r_p22, r_x, r_y;
    logic [5:0]  r_cnt;
    logic [AW-1:0] r_acc, r_save, r_base;
    logic [65:0] r_d;
    logic [BW-1:0] r_up, r_lmag, r_umag;
    logic        r_lneg, r_upos;
    logic        r_out_valid;

    logic [16:0] dmag;
    logic        dneg;
    logic [18:0] ap_s, dp_s, k_s;
    logic [35:0] n_val, nk;
    logic        div_go;
    logic [18:0] rem_sh;
    logic        rem_ge;
    logic [2*MW-1:0] prod;
    logic [AW-1:0] term_u, term, src_v, acc_n;
    logic        below, pcf, cmp_lt, cmp_gt;
    logic [BW-1:0] lo_val, lb, ub;
    logic [32:0] d_x_r, d_y_r, d_x_o, d_y_o;
    logic [16:0] dv_s;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == v2xpc_pkg::ST_IDLE);
    assign o_valid     = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_limit <= v2xpc_pkg::RST_RANGE_LIMIT;
            r_max_speed   <= v2xpc_pkg::RST_MAX_SPEED;
            r_max_accel   <= v2xpc_pkg::RST_MAX_ACCEL;
            r_max_decel   <= v2xpc_pkg::RST_MAX_DECEL;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                v2xpc_pkg::REG_RANGE_LIMIT: r_range_limit <= i_cfg_data;
                v2xpc_pkg::REG_MAX_SPEED:   r_max_speed   <= i_cfg_data[15:0];
                v2xpc_pkg::REG_MAX_ACCEL:   r_max_accel   <= i_cfg_data[15:0];
                v2xpc_pkg::REG_MAX_DECEL:   r_max_decel   <= i_cfg_data[16:0];
            endcase
        end
    end

    // Memory: registered read, single write port shared by sweep and update.
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[f_index(i_vehicle_id)];
        if (r_state == v2xpc_pkg::ST_CLEAR) begin
            r_mem[r_clr] <= '0;
        end else if (r_state == v2xpc_pkg::ST_LOAD) begin
            r_mem[r_idx] <= {1'b1, r_px, r_py, r_spd, r_tms};
        end
    end

    always_comb begin
        dneg   = r_max_decel[16];
        dmag   = dneg ? (17'd0 - r_max_decel) : r_max_decel;
        ap_s   = r_apneg ? (19'd0 - {2'b00, r_apmag}) : {2'b00, r_apmag};
        dp_s   = r_dpneg ? (19'd0 - {2'b00, r_dpmag}) : {2'b00, r_dpmag};
        k_s    = ap_s - dp_s;
        n_val  = r_acc[35:0];
        nk     = r_kneg ? (36'd0 - n_val) : n_val;
        div_go = (r_kmag != 18'd0) && !nk[35] && (nk != 36'd0);
        rem_sh = {r_rem, r_quo[33]};
        rem_ge = (rem_sh >= {1'b0, r_kmag});
        cmp_lt = ($signed(r_save) < $signed(r_acc));
        cmp_gt = ($signed(r_save) > $signed(r_acc));
        below  = r_upos && cmp_lt;
        pcf    = !(r_above && below);
        lo_val = r_acc[BW-1:0];
        lb     = r_dvneg ? r_up : lo_val;
        ub     = r_dvneg ? lo_val : r_up;
        d_x_r  = v2xpc_pkg::f_absdiff(r_px, r_rx);
        d_y_r  = v2xpc_pkg::f_absdiff(r_py, r_ry);
        d_x_o  = v2xpc_pkg::f_absdiff(r_rd[95:64], r_px);
        d_y_o  = v2xpc_pkg::f_absdiff(r_rd[63:32], r_py);
        dv_s   = {1'b0, r_spd} - {1'b0, r_rd[31:16]};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            v2xpc_pkg::ST_CLEAR:  if (r_clr == CLR_LAST) n_state = v2xpc_pkg::ST_IDLE;
            v2xpc_pkg::ST_IDLE:   if (i_valid) n_state = v2xpc_pkg::ST_LOAD;
            v2xpc_pkg::ST_LOAD:   n_state = v2xpc_pkg::ST_RSQ0;
            v2xpc_pkg::ST_RSQ0:   n_state = v2xpc_pkg::ST_RSQ1;
            v2xpc_pkg::ST_RSQ1:   n_state = v2xpc_pkg::ST_RLIM;
            v2xpc_pkg::ST_RLIM:   n_state = v2xpc_pkg::ST_DV;
            v2xpc_pkg::ST_DV:     n_state = v2xpc_pkg::ST_ADT;
            v2xpc_pkg::ST_ADT:    n_state = v2xpc_pkg::ST_DDT;
            v2xpc_pkg::ST_DDT:    n_state = v2xpc_pkg::ST_NUM;
            v2xpc_pkg::ST_NUM:    n_state = v2xpc_pkg::ST_DIVSET;
            v2xpc_pkg::ST_DIVSET: n_state = div_go ? v2xpc_pkg::ST_DIV : v2xpc_pkg::ST_TSET;
            v2xpc_pkg::ST_DIV:    if (r_cnt == 6'd1) n_state = v2xpc_pkg::ST_TSET;
            v2xpc_pkg::ST_TSET:   n_state = v2xpc_pkg::ST_P11;
            v2xpc_pkg::ST_P11:    n_state = v2xpc_pkg::ST_P12;
            v2xpc_pkg::ST_P12:    n_state = v2xpc_pkg::ST_P22;
            v2xpc_pkg::ST_P22:    n_state = v2xpc_pkg::ST_XB;
            v2xpc_pkg::ST_XB:     n_state = v2xpc_pkg::ST_YB;
            v2xpc_pkg::ST_YB:     n_state = v2xpc_pkg::ST_UP0;
            v2xpc_pkg::ST_UP0:    n_state = v2xpc_pkg::ST_UP1;
            v2xpc_pkg::ST_UP1:    n_state = v2xpc_pkg::ST_LO0;
            v2xpc_pkg::ST_LO0:    n_state = v2xpc_pkg::ST_LO1;
            v2xpc_pkg::ST_LO1:    n_state = v2xpc_pkg::ST_DO0;
            v2xpc_pkg::ST_DO0:    n_state = v2xpc_pkg::ST_DO1;
            v2xpc_pkg::ST_DO1:    n_state = v2xpc_pkg::ST_S0;
            v2xpc_pkg::ST_S0:     n_state = v2xpc_pkg::ST_S1;
            v2xpc_pkg::ST_S1:     n_state = v2xpc_pkg::ST_S2;
            v2xpc_pkg::ST_S2:     n_state = v2xpc_pkg::ST_L1;
            v2xpc_pkg::ST_L1:     n_state = v2xpc_pkg::ST_L2;
            v2xpc_pkg::ST_L2:     n_state = v2xpc_pkg::ST_U0;
            v2xpc_pkg::ST_U0:     n_state = v2xpc_pkg::ST_U1;
            v2xpc_pkg::ST_U1:     n_state = v2xpc_pkg::ST_U2;
            v2xpc_pkg::ST_U2:     n_state = v2xpc_pkg::ST_DONE;
            v2xpc_pkg::ST_DONE:   if (!r_out_valid || i_ready) n_state = v2xpc_pkg::ST_IDLE;
            default:              n_state = v2xpc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        mac.en   = 1'b1;
        mac.src  = v2xpc_pkg::SRC_ZERO;
        mac.op_a = '0;
        mac.op_b = '0;
        mac.neg  = 1'b0;
        mac.sh   = 6'd0;
        unique case (r_state)
            v2xpc_pkg::ST_RSQ0: begin
                mac.op_a = {1'b0, r_dxr};
                mac.op_b = {1'b0, r_dxr};
            end
            v2xpc_pkg::ST_RSQ1: begin
                mac.src  = v2xpc_pkg::SRC_ACC;
                mac.op_a = {1'b0, r_dyr};
                mac.op_b = {1'b0, r_dyr};
            end
            v2xpc_pkg::ST_RLIM: begin
                mac.op_a = {2'b00, r_range_limit};
                mac.op_b = {2'b00, r_range_limit};
            end
            v2xpc_pkg::ST_DV: begin
                mac.op_a = MW'(v2xpc_pkg::MS_PER_S);
                mac.op_b = {18'd0, r_dvmag};
                mac.neg  = r_dvneg;
            end
            v2xpc_pkg::ST_ADT: begin
                mac.op_a = {18'd0, r_max_accel};
                mac.op_b = {18'd0, r_dt};
            end
            v2xpc_pkg::ST_DDT: begin
                mac.op_a = {17'd0, dmag};
                mac.op_b = {18'd0, r_dt};
                mac.neg  = dneg;
            end
            v2xpc_pkg::ST_NUM: begin
                mac.src  = v2xpc_pkg::SRC_SAVE;
                mac.op_a = {17'd0, r_dpmag};
                mac.op_b = {18'd0, r_dt};
                mac.neg  = !r_dpneg;
            end
            v2xpc_pkg::ST_P11: begin
                mac.op_a = {18'd0, r_t1};
                mac.op_b = {18'd0, r_t1};
            end
            v2xpc_pkg::ST_P12: begin
                mac.op_a = {18'd0, r_t1};
                mac.op_b = {18'd0, r_t2};
            end
            v2xpc_pkg::ST_P22: begin
                mac.op_a = {18'd0, r_t2};
                mac.op_b = {18'd0, r_t2};
            end
            v2xpc_pkg::ST_XB: begin
                mac.op_a = MW'(v2xpc_pkg::MS2_PER_S);
                mac.op_b = {18'd0, r_v0};
            end
            v2xpc_pkg::ST_YB: begin
                mac.op_a = r_acc[MW-1:0];
                mac.op_b = {18'd0, r_dt};
            end
            v2xpc_pkg::ST_UP0: begin
                mac.src  = v2xpc_pkg::SRC_ACC;
                mac.op_a = {17'd0, r_apmag};
                mac.op_b = r_x;
                mac.neg  = r_apneg;
            end
            v2xpc_pkg::ST_UP1: begin
                mac.src  = v2xpc_pkg::SRC_ACC;
                mac.op_a = {17'd0, r_dpmag};
                mac.op_b = r_p22;
                mac.neg  = r_dpneg;
            end
            v2xpc_pkg::ST_LO0: begin
                mac.src  = v2xpc_pkg::SRC_BASE;
                mac.op_a = {17'd0, r_dpmag};
                mac.op_b = r_y;
                mac.neg  = r_dpneg;
            end
            v2xpc_pkg::ST_LO1: begin
                mac.src  = v2xpc_pkg::SRC_ACC;
                mac.op_a = {17'd0, r_apmag};
                mac.op_b = r_p11;
                mac.neg  = r_apneg;
            end
            v2xpc_pkg::ST_DO0: begin
                mac.op_a = {1'b0, r_dxo};
                mac.op_b = {1'b0, r_dxo};
            end
            v2xpc_pkg::ST_DO1: begin
                mac.src  = v2xpc_pkg::SRC_ACC;
                mac.op_a = {1'b0, r_dyo};
                mac.op_b = {1'b0, r_dyo};
            end
            v2xpc_pkg::ST_S0: begin
                mac.op_a = {1'b0, r_acc[32:0]};
                mac.op_b = MW'(v2xpc_pkg::SCALE_ODD);
            end
            v2xpc_pkg::ST_S1: begin
                mac.src  = v2xpc_pkg::SRC_ACC;
                mac.op_a = {1'b0, r_d[65:33]};
                mac.op_b = MW'(v2xpc_pkg::SCALE_ODD);
                mac.sh   = 6'd33;
            end
            v2xpc_pkg::ST_S2: begin
                mac.op_a = {6'd0, r_lmag[27:0]};
                mac.op_b = {6'd0, r_lmag[27:0]};
            end
            v2xpc_pkg::ST_L1: begin
                mac.src  = v2xpc_pkg::SRC_ACC;
                mac.op_a = {6'd0, r_lmag[55:28]};
                mac.op_b = {6'd0, r_lmag[27:0]};
                mac.sh   = 6'd29;
            end
            v2xpc_pkg::ST_L2: begin
                mac.src  = v2xpc_pkg::SRC_ACC;
                mac.op_a = {6'd0, r_lmag[55:28]};
                mac.op_b = {6'd0, r_lmag[55:28]};
                mac.sh   = 6'd56;
            end
            v2xpc_pkg::ST_U0: begin
                mac.op_a = {6'd0, r_umag[27:0]};
                mac.op_b = {6'd0, r_umag[27:0]};
            end
            v2xpc_pkg::ST_U1: begin
                mac.src  = v2xpc_pkg::SRC_ACC;
                mac.op_a = {6'd0, r_umag[55:28]};
                mac.op_b = {6'd0, r_umag[27:0]};
                mac.sh   = 6'd29;
            end
            v2xpc_pkg::ST_U2: begin
                mac.src  = v2xpc_pkg::SRC_ACC;
                mac.op_a = {6'd0, r_umag[55:28]};
                mac.op_b = {6'd0, r_umag[55:28]};
                mac.sh   = 6'd56;
            end
            default: begin
                mac.en = 1'b0;
            end
        endcase
    end

    always_comb begin
        prod   = mac.op_a * mac.op_b;
        term_u = {{(AW-2*MW){1'b0}}, prod} << mac.sh;
        term   = mac.neg ? (AW'(0) - term_u) : term_u;
        unique case (mac.src)
            v2xpc_pkg::SRC_ZERO: src_v = '0;
            v2xpc_pkg::SRC_ACC:  src_v = r_acc;
            v2xpc_pkg::SRC_SAVE: src_v = r_save;
            v2xpc_pkg::SRC_BASE: src_v = r_base;
        endcase
        acc_n = src_v + term;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= v2xpc_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == v2xpc_pkg::ST_CLEAR) begin
                r_clr <= r_clr + IW'(1);
            end
            if (r_state == v2xpc_pkg::ST_DIVSET) begin
                r_cnt <= 6'(v2xpc_pkg::DIV_STEPS);
            end else if (r_state == v2xpc_pkg::ST_DIV) begin
                r_cnt <= r_cnt - 6'd1;
            end
            if (r_state == v2xpc_pkg::ST_DONE && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mac.en) begin
            r_acc <= acc_n;
        end
        unique case (r_state)
            v2xpc_pkg::ST_IDLE: begin
                if (i_valid) begin
                    r_idx <= f_index(i_vehicle_id);
                    r_px  <= i_pos_x;
                    r_py  <= i_pos_y;
                    r_spd <= i_speed;
                    r_tms <= i_gen_time;
                    r_rx  <= i_rx_pos_x;
                    r_ry  <= i_rx_pos_y;
                end
            end
            v2xpc_pkg::ST_LOAD: begin
                r_had   <= r_rd[96];
                r_dxr   <= d_x_r;
                r_dyr   <= d_y_r;
                r_dxo   <= d_x_o;
                r_dyo   <= d_y_o;
                r_dt    <= r_tms - r_rd[15:0];
                r_v0    <= r_rd[31:16];
                r_dvneg <= dv_s[16];
                r_dvmag <= dv_s[16] ? 16'(17'd0 - dv_s) : dv_s[15:0];
                r_sf    <= (r_spd > r_max_speed);
                if (dv_s[16]) begin
                    r_apmag <= dmag;
                    r_apneg <= dneg;
                    r_dpmag <= {1'b0, r_max_accel};
                    r_dpneg <= 1'b0;
                end else begin
                    r_apmag <= {1'b0, r_max_accel};
                    r_apneg <= 1'b0;
                    r_dpmag <= dmag;
                    r_dpneg <= dneg;
                end
            end
            v2xpc_pkg::ST_RLIM: r_save <= r_acc;
            v2xpc_pkg::ST_DV:   r_rf   <= !cmp_lt;
            v2xpc_pkg::ST_ADT:  r_save <= r_acc;
            v2xpc_pkg::ST_DDT:  r_c2   <= cmp_lt;
            v2xpc_pkg::ST_NUM: begin
                r_scf  <= !(cmp_gt && r_c2);
                r_kneg <= k_s[18];
                r_kmag <= k_s[18] ? 18'(19'd0 - k_s) : k_s[17:0];
            end
            v2xpc_pkg::ST_DIVSET: begin
                r_rem <= '0;
                r_quo <= div_go ? nk[33:0] : 34'd0;
            end
            v2xpc_pkg::ST_DIV: begin
                r_rem <= rem_ge ? 18'(rem_sh - {1'b0, r_kmag}) : rem_sh[17:0];
                r_quo <= {r_quo[32:0], rem_ge};
            end
            v2xpc_pkg::ST_TSET: begin
                if (r_quo > {18'd0, r_dt}) begin
                    r_t1 <= r_dt;
                    r_t2 <= 16'd0;
                end else begin
                    r_t1 <= r_quo[15:0];
                    r_t2 <= r_dt - r_quo[15:0];
                end
            end
            v2xpc_pkg::ST_P12: r_p11 <= r_acc[33:0];
            v2xpc_pkg::ST_P22: r_p12 <= r_acc[33:0];
            v2xpc_pkg::ST_XB: begin
                r_p22 <= r_acc[33:0];
                r_x   <= r_p11 + {r_p12[32:0], 1'b0};
            end
            v2xpc_pkg::ST_YB:  r_y    <= r_p22 + {r_p12[32:0], 1'b0};
            v2xpc_pkg::ST_UP0: r_base <= r_acc;
            v2xpc_pkg::ST_LO0: r_up   <= r_acc[BW-1:0];
            v2xpc_pkg::ST_DO0: begin
                r_lneg <= lb[BW-1];
                r_lmag <= lb[BW-1] ? (BW'(0) - lb) : lb;
                r_upos <= !ub[BW-1] && (ub != '0);
                r_umag <= ub[BW-1] ? (BW'(0) - ub) : ub;
            end
            v2xpc_pkg::ST_S0: r_d    <= r_acc[65:0];
            v2xpc_pkg::ST_S2: r_save <= r_acc << v2xpc_pkg::SCALE_SH;
            v2xpc_pkg::ST_U0: r_above <= r_lneg || cmp_gt;
            v2xpc_pkg::ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    o_had_previous    <= r_had;
                    o_range_fail      <= r_had & r_rf;
                    o_speed_fail      <= r_had & r_sf;
                    o_speed_cons_fail <= r_had & r_scf;
                    o_pos_cons_fail   <= r_had & pcf;
                    o_misbehaving     <= r_had & (r_rf | r_sf | r_scf | pcf);
                end
            end
            default: begin
            end
        endcase
    end

endmodule
